// ----- src/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int PRIO_W       = 16;
    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 16;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CUTIN  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] data;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_INS_CHK,
        S_INS_CMP,
        S_INS_WR,
        S_REM_HEAD,
        S_REM_HEAD_WAIT,
        S_REM_RD,
        S_REM_WR,
        S_REPORT,
        S_MID_WAIT,
        S_LAST_WAIT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- src/sorted_priority_queue.sv -----
// Sorted min-priority queue: sequencer, compare/shift datapath and entry store.
// Depends on spq_pkg and spq_ram.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | s_valid s_ready s_op s_priority_req     | in
//          | s_payload                               |
//  result  | m_valid m_ready m_removed_data m_status | out
//          | m_entry_count m_is_empty m_middle_data  |
//          | m_last_data                             |
//
// One request is handled at a time through one RAM read port and one compare unit.
// Insert shifts each entry with a higher priority value up one slot, then writes the new
// entry; remove reads the head and shifts every later entry down one slot; cut-in first
// reads the head priority. The report then reads two entries, the middle and the last.
// Reset clears the count and control state; entry contents need no clearing.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_op,
    input  wire logic signed [spq_pkg::PRIO_W-1:0]   s_priority_req,
    input  wire logic signed [spq_pkg::DATA_W-1:0]   s_payload,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [spq_pkg::DATA_W-1:0]        m_removed_data,
    output logic [1:0]                               m_status,
    output logic [$clog2(CAPACITY+1)-1:0]            m_entry_count,
    output logic                                     m_is_empty,
    output logic signed [spq_pkg::DATA_W-1:0]        m_middle_data,
    output logic signed [spq_pkg::DATA_W-1:0]        m_last_data
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    state_t                   state_reg, state_next;
    logic signed [PRIO_W-1:0] prio_reg, prio_next;
    logic signed [DATA_W-1:0] data_reg, data_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [CW-1:0]            occ_reg, occ_next;
    status_t                  stat_reg, stat_next;
    logic signed [DATA_W-1:0] removed_reg, removed_next;
    logic signed [DATA_W-1:0] mid_reg, mid_next;
    logic signed [DATA_W-1:0] last_reg, last_next;

    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] o_removed_reg, o_removed_next;
    status_t                  o_stat_reg, o_stat_next;
    logic [CW-1:0]            o_count_reg, o_count_next;
    logic signed [DATA_W-1:0] o_mid_reg, o_mid_next;
    logic signed [DATA_W-1:0] o_last_reg, o_last_next;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    entry_t                   ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rword;
    entry_t                   rd_entry;
    logic [CW-1:0]            idx_m1;
    logic [CW-1:0]            occ_m1;
    logic [CW-1:0]            occ_half;
    logic                     is_full;

    spq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rword)
    );

    assign rd_entry = entry_t'(ram_rword);
    assign idx_m1   = idx_reg - 1'b1;
    assign occ_m1   = occ_reg - 1'b1;
    assign occ_half = occ_reg >> 1;
    assign is_full  = (occ_reg == CW'(CAPACITY));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg      <= prio_next;
        data_reg      <= data_next;
        idx_reg       <= idx_next;
        stat_reg      <= stat_next;
        removed_reg   <= removed_next;
        mid_reg       <= mid_next;
        last_reg      <= last_next;
        o_removed_reg <= o_removed_next;
        o_stat_reg    <= o_stat_next;
        o_count_reg   <= o_count_next;
        o_mid_reg     <= o_mid_next;
        o_last_reg    <= o_last_next;
    end

    always_comb begin
        state_next     = state_reg;
        prio_next      = prio_reg;
        data_next      = data_reg;
        idx_next       = idx_reg;
        occ_next       = occ_reg;
        stat_next      = stat_reg;
        removed_next   = removed_reg;
        mid_next       = mid_reg;
        last_next      = last_reg;
        m_valid_next   = m_valid_reg;
        o_removed_next = o_removed_reg;
        o_stat_next    = o_stat_reg;
        o_count_next   = o_count_reg;
        o_mid_next     = o_mid_reg;
        o_last_next    = o_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[AW-1:0];
        ram_wdata      = rd_entry;
        ram_raddr      = idx_m1[AW-1:0];
        s_ready        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    prio_next    = s_priority_req;
                    data_next    = s_payload;
                    stat_next    = STAT_OK;
                    removed_next = '0;
                    idx_next     = occ_reg;
                    case (op_t'(s_op))
                        OP_INSERT: begin
                            if (is_full) begin
                                stat_next  = STAT_FULL;
                                state_next = S_REPORT;
                            end else begin
                                state_next = S_INS_CHK;
                            end
                        end
                        OP_REMOVE: begin
                            if (occ_reg == '0) begin
                                stat_next  = STAT_EMPTY;
                                state_next = S_REPORT;
                            end else begin
                                state_next = S_REM_HEAD;
                            end
                        end
                        OP_CUTIN: begin
                            if (is_full) begin
                                stat_next  = STAT_FULL;
                                state_next = S_REPORT;
                            end else if (occ_reg == '0) begin
                                prio_next  = '0;
                                state_next = S_INS_CHK;
                            end else begin
                                state_next = S_HEAD_RD;
                            end
                        end
                        default: begin
                            state_next = S_REPORT;
                        end
                    endcase
                end
            end
            S_HEAD_RD: begin
                ram_raddr  = '0;
                state_next = S_HEAD_WAIT;
            end
            S_HEAD_WAIT: begin
                if (rd_entry.prio == PRIO_MIN) begin
                    prio_next = PRIO_MIN;
                end else begin
                    prio_next = rd_entry.prio - 1'b1;
                end
                state_next = S_INS_CHK;
            end
            S_INS_CHK: begin
                if (idx_reg == '0) begin
                    state_next = S_INS_WR;
                end else begin
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (rd_entry.prio > prio_reg) begin
                    ram_we     = 1'b1;
                    idx_next   = idx_m1;
                    state_next = S_INS_CHK;
                end else begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR: begin
                ram_we         = 1'b1;
                ram_wdata.prio = prio_reg;
                ram_wdata.data = data_reg;
                occ_next       = occ_reg + 1'b1;
                state_next     = S_REPORT;
            end
            S_REM_HEAD: begin
                ram_raddr  = '0;
                state_next = S_REM_HEAD_WAIT;
            end
            S_REM_HEAD_WAIT: begin
                removed_next = rd_entry.data;
                idx_next     = CW'(1);
                state_next   = S_REM_RD;
            end
            S_REM_RD: begin
                ram_raddr = idx_reg[AW-1:0];
                if (idx_reg == occ_reg) begin
                    occ_next   = occ_m1;
                    state_next = S_REPORT;
                end else begin
                    state_next = S_REM_WR;
                end
            end
            S_REM_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = idx_m1[AW-1:0];
                idx_next   = idx_reg + 1'b1;
                state_next = S_REM_RD;
            end
            S_REPORT: begin
                ram_raddr = occ_half[AW-1:0];
                if (occ_reg == '0) begin
                    mid_next   = '0;
                    last_next  = '0;
                    state_next = S_DONE;
                end else begin
                    state_next = S_MID_WAIT;
                end
            end
            S_MID_WAIT: begin
                ram_raddr  = occ_m1[AW-1:0];
                mid_next   = rd_entry.data;
                state_next = S_LAST_WAIT;
            end
            S_LAST_WAIT: begin
                last_next  = rd_entry.data;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    o_removed_next = removed_reg;
                    o_stat_next    = stat_reg;
                    o_count_next   = occ_reg;
                    o_mid_next     = mid_reg;
                    o_last_next    = last_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_removed_data = o_removed_reg;
    assign m_status       = o_stat_reg;
    assign m_entry_count  = o_count_reg;
    assign m_is_empty     = (o_count_reg == '0);
    assign m_middle_data  = o_mid_reg;
    assign m_last_data    = o_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while another is in progress");

    a_empty_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_empty) |-> (m_middle_data == '0 && m_last_data == '0))
        else $error("empty queue reports entry data");

    a_err_no_removed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_OK) |-> (m_removed_data == '0))
        else $error("failed request reports removed data");

endmodule

`default_nettype wire

// ----- src/spq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- dv/sorted_priority_queue_tb.sv -----
// Self-checking testbench for sorted_priority_queue: directed table, then random traffic.
// Expected reports come from a behavioral queue model in this file, or from typed table rows.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

    import spq_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int COUNT_W      = $clog2(CAP + 1);
    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 1825;
    localparam int DRAIN_EVERY  = 400;
    localparam int TAIL_CYCLES  = 64;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int MAX_REPORTS  = 10;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_data;
        status_t                  status;
        logic [COUNT_W-1:0]       entry_count;
        logic                     is_empty;
        logic signed [DATA_W-1:0] middle_data;
        logic signed [DATA_W-1:0] last_data;
    } report_t;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] payload;
        logic                     typed;
        report_t                  want;
    } row_t;

    localparam report_t NO_REPORT = '0;

    localparam logic signed [PRIO_W-1:0] EDGE_PRIOS [7] = '{
        16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFE, 16'h7FFF
    };
    localparam logic signed [DATA_W-1:0] EDGE_DATA [4] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF
    };

    row_t directed_rows [25] = '{
        '{OP_REMOVE, 16'h0000, 32'h0000_0000, 1'b1,
          '{32'h0, STAT_EMPTY, 5'd0, 1'b1, 32'h0, 32'h0}},
        '{OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
          '{32'h0, STAT_OK, 5'd0, 1'b1, 32'h0, 32'h0}},
        '{OP_CUTIN, 16'h7FFF, 32'h1234_5678, 1'b1,
          '{32'h0, STAT_OK, 5'd1, 1'b0, 32'h1234_5678, 32'h1234_5678}},
        '{OP_INSERT, 16'h7FFF, 32'h7FFF_FFFF, 1'b0, NO_REPORT},
        '{OP_INSERT, 16'h8000, 32'h8000_0000, 1'b0, NO_REPORT},
        '{OP_INSERT, 16'h8000, 32'hFFFF_FFFF, 1'b0, NO_REPORT},
        '{OP_CUTIN, 16'h0000, 32'h0000_0000, 1'b0, NO_REPORT},
        '{OP_INSERT, 16'h0000, 32'h5555_5555, 1'b0, NO_REPORT},
        '{OP_INSERT, 16'h0000, 32'hAAAA_AAAA, 1'b0, NO_REPORT},
        '{OP_UNUSED, 16'h1234, 32'hDEAD_BEEF, 1'b0, NO_REPORT},
        '{OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, NO_REPORT},
        '{OP_INSERT, 16'h0001, 32'h0000_0001, 1'b0, NO_REPORT},
        '{OP_INSERT, 16'hFFFF, 32'h0000_0002, 1'b0, NO_REPORT},
        '{OP_INSERT, 16'h0064, 32'h0000_0003, 1'b0, NO_REPORT},
        '{OP_INSERT, 16'hFF9C, 32'h0000_0004, 1'b0, NO_REPORT},
        '{OP_INSERT, 16'h7FFE, 32'h0000_0005, 1'b0, NO_REPORT},
        '{OP_INSERT, 16'h8001, 32'h0000_0006, 1'b0, NO_REPORT},
        '{OP_INSERT, 16'h0002, 32'h0000_0007, 1'b0, NO_REPORT},
        '{OP_INSERT, 16'hFFFE, 32'h0000_0008, 1'b0, NO_REPORT},
        '{OP_INSERT, 16'h0000, 32'h0000_0009, 1'b0, NO_REPORT},
        '{OP_INSERT, 16'h7FFF, 32'h0000_000A, 1'b0, NO_REPORT},
        '{OP_INSERT, 16'h8000, 32'h0BAD_F00D, 1'b0, NO_REPORT},
        '{OP_CUTIN, 16'h0000, 32'hC0DE_CAFE, 1'b0, NO_REPORT},
        '{OP_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, NO_REPORT},
        '{OP_CUTIN, 16'h5A5A, 32'h3C3C_3C3C, 1'b0, NO_REPORT}
    };

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_op;
    logic signed [PRIO_W-1:0] s_priority_req;
    logic signed [DATA_W-1:0] s_payload;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_removed_data;
    logic [1:0]               m_status;
    logic [COUNT_W-1:0]       m_entry_count;
    logic                     m_is_empty;
    logic signed [DATA_W-1:0] m_middle_data;
    logic signed [DATA_W-1:0] m_last_data;

    logic signed [PRIO_W-1:0] q_prio [CAP];
    logic signed [DATA_W-1:0] q_data [CAP];
    int                       q_count = 0;

    report_t pending_reports [$];
    int      mismatch_count = 0;
    int      cycle_count;
    bit      tx_quiet = 1'b0;
    bit      rx_quiet = 1'b0;

    sorted_priority_queue #(
        .CAPACITY(CAP)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_priority_req (s_priority_req),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_removed_data (m_removed_data),
        .m_status       (m_status),
        .m_entry_count  (m_entry_count),
        .m_is_empty     (m_is_empty),
        .m_middle_data  (m_middle_data),
        .m_last_data    (m_last_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic int next_wait(input bit quiet);
        if (quiet || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic bit place_entry(input logic signed [PRIO_W-1:0] prio,
                                       input logic signed [DATA_W-1:0] data);
        int pos;
        if (q_count >= CAP) begin
            return 1'b0;
        end
        pos = 0;
        while (pos < q_count && q_prio[pos] <= prio) begin
            pos++;
        end
        for (int i = q_count; i > pos; i--) begin
            q_prio[i] = q_prio[i-1];
            q_data[i] = q_data[i-1];
        end
        q_prio[pos] = prio;
        q_data[pos] = data;
        q_count++;
        return 1'b1;
    endfunction

    task automatic advance_queue(input logic [1:0] op, input logic signed [PRIO_W-1:0] prio,
                                 input logic signed [DATA_W-1:0] data, output report_t rep);
        logic signed [PRIO_W-1:0] head_prio;
        rep = NO_REPORT;
        rep.status = STAT_OK;
        case (op)
            OP_INSERT: begin
                if (!place_entry(prio, data)) begin
                    rep.status = STAT_FULL;
                end
            end
            OP_REMOVE: begin
                if (q_count == 0) begin
                    rep.status = STAT_EMPTY;
                end else begin
                    rep.removed_data = q_data[0];
                    for (int i = 1; i < q_count; i++) begin
                        q_prio[i-1] = q_prio[i];
                        q_data[i-1] = q_data[i];
                    end
                    q_count--;
                end
            end
            OP_CUTIN: begin
                head_prio = '0;
                if (q_count > 0) begin
                    head_prio = q_prio[0];
                    if (head_prio != PRIO_MIN) begin
                        head_prio = PRIO_W'(head_prio - 1);
                    end
                end
                if (!place_entry(head_prio, data)) begin
                    rep.status = STAT_FULL;
                end
            end
            default: begin
            end
        endcase
        rep.entry_count = COUNT_W'(q_count);
        rep.is_empty    = (q_count == 0);
        if (q_count > 0) begin
            rep.middle_data = q_data[q_count/2];
            rep.last_data   = q_data[q_count-1];
        end
    endtask

    // Call right after a rising edge; returns at the edge that accepts the request.
    task automatic send_request(input logic [1:0] op, input logic signed [PRIO_W-1:0] prio,
                                input logic signed [DATA_W-1:0] data, input bit typed,
                                input report_t typed_report);
        int      gap;
        report_t predicted;
        @(negedge aclk);
        gap = next_wait(tx_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_priority_req <= prio;
        s_payload      <= data;
        do @(posedge aclk); while (!s_ready);
        advance_queue(op, prio, data, predicted);
        pending_reports.push_back(typed ? typed_report : predicted);
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin : request_source
        int                       random_sent;
        int                       next_drain;
        int                       seg_len;
        int                       fill_pct;
        int                       prio_kind;
        int                       pick;
        logic [1:0]               op;
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] data;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_op           = OP_INSERT;
        s_priority_req = '0;
        s_payload      = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].op, directed_rows[i].prio, directed_rows[i].payload,
                         directed_rows[i].typed, directed_rows[i].want);
        end
        hold_until_drained();

        random_sent = 0;
        next_drain  = DRAIN_EVERY;
        while (random_sent < RANDOM_ITEMS) begin
            seg_len   = $urandom_range(16, 96);
            fill_pct  = ($urandom_range(0, 2) == 0) ? 65 : ($urandom_range(0, 1) ? 20 : 40);
            prio_kind = $urandom_range(0, 2);
            tx_quiet  = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < seg_len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    op = OP_UNUSED;
                end else if (pick < 3 + fill_pct) begin
                    op = OP_INSERT;
                end else if (pick < 15 + fill_pct) begin
                    op = OP_CUTIN;
                end else begin
                    op = OP_REMOVE;
                end
                case (prio_kind)
                    0: prio = PRIO_W'($urandom_range(0, 6) - 3);
                    1: prio = PRIO_W'($urandom);
                    default: prio = EDGE_PRIOS[$urandom_range(0, 6)];
                endcase
                data = ($urandom_range(0, 15) == 0) ? EDGE_DATA[$urandom_range(0, 3)] : $urandom;
                send_request(op, prio, data, 1'b0, NO_REPORT);
                if (op != OP_UNUSED) begin
                    random_sent++;
                end
                if (random_sent >= next_drain) begin
                    hold_until_drained();
                    next_drain += DRAIN_EVERY;
                end
            end
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        int stall;
        int taken;
        m_ready = 1'b0;
        taken   = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (taken % 50 == 0) begin
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            stall = next_wait(rx_quiet);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    always @(posedge aclk) begin : result_check
        report_t got;
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_removed_data, status_t'(m_status), m_entry_count, m_is_empty,
                    m_middle_data, m_last_data};
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected result at %0t: removed=%h status=%0d count=%0d",
                             $time, m_removed_data, m_status, m_entry_count);
                end
            end else begin
                want = pending_reports.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("result mismatch at %0t", $time);
                        $display("  expected rem=%h status=%0d count=%0d empty=%b mid=%h last=%h",
                                 want.removed_data, want.status, want.entry_count,
                                 want.is_empty, want.middle_data, want.last_data);
                        $display("  actual   rem=%h status=%0d count=%0d empty=%b mid=%h last=%h",
                                 m_removed_data, m_status, m_entry_count,
                                 m_is_empty, m_middle_data, m_last_data);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule
